[sv/gest_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gest_pkg
// Shared types and constants of the gamepad event state tracker.
// ----------------------------------------------------------------------------
package gest_pkg;

    // Action codes of an input word.
    localparam logic [1:0] ACT_FRAME = 2'd0;
    localparam logic [1:0] ACT_EVENT = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Event types, init flag already stripped.
    localparam logic [6:0] EV_BUTTON = 7'd1;
    localparam logic [6:0] EV_AXIS   = 7'd2;

    // Dpad flag bit positions.
    localparam int DP_UP    = 0;
    localparam int DP_DOWN  = 1;
    localparam int DP_LEFT  = 2;
    localparam int DP_RIGHT = 3;

    // Axes that drive the dpad, and the left stick axes it overrides.
    localparam logic [2:0] AXIS_DPAD_X = 3'd6;
    localparam logic [2:0] AXIS_DPAD_Y = 3'd7;
    localparam logic [2:0] AXIS_LEFT_X = 3'd0;
    localparam logic [2:0] AXIS_LEFT_Y = 3'd1;

    localparam logic signed [15:0] DPAD_THRESH = 16'sd10000;
    localparam logic signed [15:0] AXIS_FULL   = 16'sd32767;

    // Configuration registers.
    localparam logic       REG_DEADBAND   = 1'b0;
    localparam logic [15:0] DEADBAND_RESET = 16'd800;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         event_type;
        logic [7:0]         event_number;
        logic signed [15:0] event_value;
        logic [2:0]         axis_select;
    } t_in_word;

    typedef struct packed {
        logic [15:0]        buttons_held;
        logic [15:0]        buttons_pressed;
        logic [15:0]        buttons_released;
        logic [3:0]         dpad_held;
        logic [3:0]         dpad_pressed;
        logic [3:0]         dpad_released;
        logic signed [15:0] axis_value;
        logic signed [15:0] axis_deadbanded;
    } t_out_word;

    // Post-update state view handed from the state core to the result logic.
    typedef struct packed {
        logic [15:0]        btn_now;
        logic [15:0]        btn_prev;
        logic [3:0]         dpad_now;
        logic [3:0]         dpad_prev;
        logic [2:0]         axis_sel;
        logic signed [15:0] axis_raw;
    } t_snap;

endpackage
`default_nettype wire

[sv/gest_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gest_cfg
// APB-style register port holding the deadband setting.
// ----------------------------------------------------------------------------
module gest_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [15:0]      o_deadband
);
    import gest_pkg::*;

    logic [15:0] r_deadband;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= DEADBAND_RESET;
        end else if (w_wr && paddr[2] == REG_DEADBAND) begin
            r_deadband <= pwdata[15:0];
        end
    end

    // Low two address bits are the byte lane and are ignored.
    always_comb begin
        if (paddr[2] == REG_DEADBAND) begin
            prdata = {16'd0, r_deadband};
        end else begin
            prdata = 32'd0;
        end
    end

    assign o_deadband = r_deadband;

endmodule
`default_nettype wire

[sv/gest_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gest_core
// Button, dpad and axis state; applies one word per cycle while i_accept is
// high and exposes the post-update state.
// ----------------------------------------------------------------------------
module gest_core #(
    parameter int NUM_BUTTONS = 16,
    parameter int NUM_AXES    = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire gest_pkg::t_in_word i_word,
    output gest_pkg::t_snap        o_snap
);
    import gest_pkg::*;

    localparam int BPW = (NUM_BUTTONS > 16) ? NUM_BUTTONS : 16;

    logic [NUM_BUTTONS-1:0] r_btn_now,  n_btn_now;
    logic [NUM_BUTTONS-1:0] r_btn_prev, n_btn_prev;
    logic [3:0]             r_dpad_now, n_dpad_now;
    logic [3:0]             r_dpad_prev, n_dpad_prev;
    logic signed [15:0]     r_axis [NUM_AXES];
    logic signed [15:0]     n_axis [NUM_AXES];

    logic [6:0]             w_type;
    logic                   w_btn_ev;
    logic                   w_axis_ev;
    logic [BPW-1:0]         w_now_pad;
    logic [BPW-1:0]         w_prev_pad;
    logic signed [15:0]     w_axis_raw;

    assign w_type    = i_word.event_type[6:0];
    assign w_btn_ev  = (i_word.action == ACT_EVENT) && (w_type == EV_BUTTON);
    assign w_axis_ev = (i_word.action == ACT_EVENT) && (w_type == EV_AXIS);

    always_comb begin
        n_btn_now   = r_btn_now;
        n_btn_prev  = r_btn_prev;
        n_dpad_now  = r_dpad_now;
        n_dpad_prev = r_dpad_prev;
        for (int a = 0; a < NUM_AXES; a++) begin
            n_axis[a] = r_axis[a];
        end

        if (i_word.action == ACT_FRAME) begin
            n_btn_prev  = r_btn_now;
            n_dpad_prev = r_dpad_now;
        end

        // Out-of-range numbers match no slot and change nothing.
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (w_btn_ev && i_word.event_number == 8'(b)) begin
                n_btn_now[b] = (i_word.event_value != 16'sd0);
            end
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            if (w_axis_ev && i_word.event_number == 8'(a)) begin
                n_axis[a] = i_word.event_value;
            end
        end

        if (w_axis_ev && i_word.event_number == 8'(AXIS_DPAD_X)) begin
            n_dpad_now[DP_LEFT]  = (i_word.event_value < -DPAD_THRESH);
            n_dpad_now[DP_RIGHT] = (i_word.event_value >  DPAD_THRESH);
        end else if (w_axis_ev && i_word.event_number == 8'(AXIS_DPAD_Y)) begin
            n_dpad_now[DP_UP]    = (i_word.event_value < -DPAD_THRESH);
            n_dpad_now[DP_DOWN]  = (i_word.event_value >  DPAD_THRESH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_now   <= '0;
            r_btn_prev  <= '0;
            r_dpad_now  <= '0;
            r_dpad_prev <= '0;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_axis[a] <= '0;
            end
        end else if (i_accept) begin
            r_btn_now   <= n_btn_now;
            r_btn_prev  <= n_btn_prev;
            r_dpad_now  <= n_dpad_now;
            r_dpad_prev <= n_dpad_prev;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_axis[a] <= n_axis[a];
            end
        end
    end

    // axis_select reaches only the low eight axes.
    always_comb begin
        w_axis_raw = '0;
        for (int a = 0; a < 8; a++) begin
            if (i_word.axis_select == 3'(a)) begin
                w_axis_raw = n_axis[a];
            end
        end
    end

    assign w_now_pad  = BPW'(n_btn_now);
    assign w_prev_pad = BPW'(n_btn_prev);

    assign o_snap.btn_now   = w_now_pad[15:0];
    assign o_snap.btn_prev  = w_prev_pad[15:0];
    assign o_snap.dpad_now  = n_dpad_now;
    assign o_snap.dpad_prev = n_dpad_prev;
    assign o_snap.axis_sel  = i_word.axis_select;
    assign o_snap.axis_raw  = w_axis_raw;

endmodule
`default_nettype wire

[sv/gest_result.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gest_result
// Forms edge masks, the dpad override and the deadbanded axis value.
// ----------------------------------------------------------------------------
module gest_result (
    input  wire gest_pkg::t_snap i_snap,
    input  wire logic [15:0]     i_deadband,
    output gest_pkg::t_out_word  o_word
);
    import gest_pkg::*;

    logic signed [15:0] w_av;
    logic signed [17:0] w_av_x;
    logic signed [17:0] w_db_x;
    logic               w_inside;

    always_comb begin
        w_av = i_snap.axis_raw;
        unique case (i_snap.axis_sel)
            AXIS_LEFT_X, AXIS_DPAD_X: begin
                if (i_snap.dpad_now[DP_RIGHT]) begin
                    w_av = AXIS_FULL;
                end else if (i_snap.dpad_now[DP_LEFT]) begin
                    w_av = -AXIS_FULL;
                end
            end
            AXIS_LEFT_Y, AXIS_DPAD_Y: begin
                if (i_snap.dpad_now[DP_UP]) begin
                    w_av = -AXIS_FULL;
                end else if (i_snap.dpad_now[DP_DOWN]) begin
                    w_av = AXIS_FULL;
                end
            end
            default: begin
                w_av = i_snap.axis_raw;
            end
        endcase
    end

    // 18-bit compare so the full unsigned deadband range works.
    assign w_av_x   = 18'(w_av);
    assign w_db_x   = $signed({2'b00, i_deadband});
    assign w_inside = (w_av_x > -w_db_x) && (w_av_x < w_db_x);

    assign o_word.buttons_held     = i_snap.btn_now;
    assign o_word.buttons_pressed  = i_snap.btn_now & ~i_snap.btn_prev;
    assign o_word.buttons_released = i_snap.btn_prev & ~i_snap.btn_now;
    assign o_word.dpad_held        = i_snap.dpad_now;
    assign o_word.dpad_pressed     = i_snap.dpad_now & ~i_snap.dpad_prev;
    assign o_word.dpad_released    = i_snap.dpad_prev & ~i_snap.dpad_now;
    assign o_word.axis_value       = w_av;
    assign o_word.axis_deadbanded  = w_inside ? 16'sd0 : w_av;

endmodule
`default_nettype wire

[sv/gamepad_event_state_tracker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_event_state_tracker
// Gamepad state from a joystick event stream, with edge masks and deadband.
// ----------------------------------------------------------------------------
// Each input word is a frame-start snapshot, a joystick event or a query,
// and each produces exactly one output word, held in the output register once it is
// accepted. A new word can be taken every cycle: the state registers update
// at the accepting edge and the result, computed from the updated state,
// lands in the output register at that same edge. Input stall is raised
// only while the output register holds a word and the sink stalls it, so
// sustained throughput is one word per cycle whenever the sink keeps up.
// The deadband register (byte address 0) resets to 800 and should be
// written only while no word is in flight.
// ----------------------------------------------------------------------------
module gamepad_event_state_tracker #(
    parameter int NUM_BUTTONS = 16,   // 1..32; only the low 16 reach the masks
    parameter int NUM_AXES    = 8     // 8..16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire gest_pkg::t_in_word i_in_word,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output gest_pkg::t_out_word     o_out_word,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import gest_pkg::*;

    logic        w_accept;
    logic [15:0] w_deadband;
    t_snap       w_snap;
    t_out_word   w_result;

    logic        r_out_valid;
    t_out_word   r_out_word;

    // The output register can always take a word unless it is full and held.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    gest_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_deadband (w_deadband)
    );

    gest_core #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .NUM_AXES    (NUM_AXES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_word   (i_in_word),
        .o_snap   (w_snap)
    );

    gest_result u_result (
        .i_snap     (w_snap),
        .i_deadband (w_deadband),
        .o_word     (w_result)
    );

    // Output register: loads on accept, empties when the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

[dv/gest_state_checker.sv]
// ----------------------------------------------------------------------------
// gest_state_checker
// Watches the tracker's channels, predicts each output word and compares.
// ----------------------------------------------------------------------------
// Keeps its own button, dpad, axis and deadband state. Each accepted input
// word is turned into one predicted report. Each accepted output word is
// checked against the oldest one. Writes on the config port are followed so
// that the deadband stays in step with the block.
// ----------------------------------------------------------------------------
module gest_state_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire gest_pkg::t_in_word  i_in_word,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire gest_pkg::t_out_word i_out_word,
    input  wire logic                i_psel,
    input  wire logic                i_penable,
    input  wire logic                i_pwrite,
    input  wire logic                i_pready,
    input  wire logic [2:0]          i_paddr,
    input  wire logic [31:0]         i_pwdata,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_reports
);
    import gest_pkg::*;

    localparam int          NUM_BUTTONS   = 16;
    localparam int          NUM_AXES      = 8;
    localparam logic [2:0]  DEADBAND_ADDR = {REG_DEADBAND, 2'b00};

    logic [15:0]        btn_now;
    logic [15:0]        btn_prev;
    logic [3:0]         dpad_now;
    logic [3:0]         dpad_prev;
    logic signed [15:0] axis_smp [0:NUM_AXES-1];
    logic [15:0]        deadband;
    t_out_word          pending_reports [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_reports = 0;
    end

    // Applies one word to the tracked state and returns the report it yields.
    function automatic t_out_word track_gamepad(input t_in_word w);
        t_out_word   r;
        logic [6:0]  ev;
        logic [2:0]  sel;
        int          smp;
        int          av;
        int          db;
        int          thr;
        ev  = w.event_type[6:0];
        sel = w.axis_select;
        smp = int'($signed(w.event_value));
        thr = int'(DPAD_THRESH);
        if (w.action == ACT_FRAME) begin
            btn_prev  = btn_now;
            dpad_prev = dpad_now;
        end else if (w.action == ACT_EVENT) begin
            if (ev == EV_BUTTON) begin
                if (w.event_number < NUM_BUTTONS)
                    btn_now[w.event_number[3:0]] = (smp != 0);
            end else if (ev == EV_AXIS) begin
                if (w.event_number < NUM_AXES)
                    axis_smp[w.event_number[2:0]] = w.event_value;
                if (w.event_number == {5'd0, AXIS_DPAD_X}) begin
                    dpad_now[DP_LEFT]  = (smp < -thr);
                    dpad_now[DP_RIGHT] = (smp > thr);
                end else if (w.event_number == {5'd0, AXIS_DPAD_Y}) begin
                    dpad_now[DP_UP]   = (smp < -thr);
                    dpad_now[DP_DOWN] = (smp > thr);
                end
            end
        end
        av = int'(axis_smp[sel]);
        if (sel == AXIS_LEFT_X || sel == AXIS_DPAD_X) begin
            if (dpad_now[DP_RIGHT])     av = int'(AXIS_FULL);
            else if (dpad_now[DP_LEFT]) av = -int'(AXIS_FULL);
        end else if (sel == AXIS_LEFT_Y || sel == AXIS_DPAD_Y) begin
            if (dpad_now[DP_UP])        av = -int'(AXIS_FULL);
            else if (dpad_now[DP_DOWN]) av = int'(AXIS_FULL);
        end
        db = int'({16'd0, deadband});
        r.buttons_held     = btn_now;
        r.buttons_pressed  = btn_now & ~btn_prev;
        r.buttons_released = btn_prev & ~btn_now;
        r.dpad_held        = dpad_now;
        r.dpad_pressed     = dpad_now & ~dpad_prev;
        r.dpad_released    = dpad_prev & ~dpad_now;
        r.axis_value       = 16'(av);
        r.axis_deadbanded  = (av > -db && av < db) ? 16'sd0 : 16'(av);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %h, got %h",
                     $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            btn_now   = '0;
            btn_prev  = '0;
            dpad_now  = '0;
            dpad_prev = '0;
            deadband  = DEADBAND_RESET;
            for (int i = 0; i < NUM_AXES; i++) axis_smp[i] = '0;
            pending_reports.delete();
        end else begin
            // outputs first: a word leaving now came from an earlier input
            if (i_out_valid && !i_out_stall) begin
                if (pending_reports.size() == 0) begin
                    o_errors++;
                    $display("%0t: output word with none expected, got %h",
                             $time, i_out_word);
                end else begin
                    want = pending_reports.pop_front();
                    o_reports++;
                    check_field("buttons_held", want.buttons_held,
                                i_out_word.buttons_held);
                    check_field("buttons_pressed", want.buttons_pressed,
                                i_out_word.buttons_pressed);
                    check_field("buttons_released", want.buttons_released,
                                i_out_word.buttons_released);
                    check_field("dpad_held", {12'd0, want.dpad_held},
                                {12'd0, i_out_word.dpad_held});
                    check_field("dpad_pressed", {12'd0, want.dpad_pressed},
                                {12'd0, i_out_word.dpad_pressed});
                    check_field("dpad_released", {12'd0, want.dpad_released},
                                {12'd0, i_out_word.dpad_released});
                    check_field("axis_value", want.axis_value,
                                i_out_word.axis_value);
                    check_field("axis_deadbanded", want.axis_deadbanded,
                                i_out_word.axis_deadbanded);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == DEADBAND_ADDR)
                deadband = i_pwdata[15:0];
            if (i_in_valid && !i_in_stall)
                pending_reports.push_back(track_gamepad(i_in_word));
        end
        o_pending = pending_reports.size();
    end

endmodule

[dv/tb_gamepad_event_state_tracker.sv]
// ----------------------------------------------------------------------------
// tb_gamepad_event_state_tracker
// Stimulus and verdict for the gamepad event state tracker.
// ----------------------------------------------------------------------------
// A short directed run walks the button, axis, dpad and deadband corner
// cases, then four pacing modes of random words follow (free running, slow
// sender, slow sink, both slow), with deadband rewrites between halves.
// Prediction and comparison sit in gest_state_checker.
// ----------------------------------------------------------------------------
module tb_gamepad_event_state_tracker;
    import gest_pkg::*;

    localparam logic [1:0] ACT_SPARE  = 2'd3;               // unused code, acts as query
    localparam logic [2:0] DB_ADDR    = {REG_DEADBAND, 2'b00};
    localparam logic [2:0] SPARE_ADDR = {~REG_DEADBAND, 2'b00}; // no register behind it
    localparam int         HALF_RUN   = 205;                // random words per half phase

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        in_valid    = 1'b0;
    t_in_word    in_word     = '0;
    logic        out_stall   = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_word;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    int          reports;

    int          idle_pct  = 0;     // chance the sender skips a cycle
    int          stall_pct = 0;     // chance the sink stalls a cycle
    int          db_now    = 800;   // deadband as last written, steers random values
    int          words_sent = 0;
    int          db_writes  = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    gamepad_event_state_tracker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    gest_state_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (o_in_stall),
        .i_in_word  (in_word),
        .i_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .i_out_word (o_out_word),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_pready   (pready),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_reports  (reports)
    );

    // Sink side: random stall, independent of what the block presents.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic t_in_word make_word(input logic [1:0] act, input logic [7:0] typ,
                                           input logic [7:0] num, input logic [15:0] val,
                                           input logic [2:0] sel);
        t_in_word w;
        w.action       = act;
        w.event_type   = typ;
        w.event_number = num;
        w.event_value  = val;
        w.axis_select  = sel;
        return w;
    endfunction

    // Axis samples cluster on the dpad threshold, the rails and the deadband
    // edge; the rest is uniform.
    function automatic logic [15:0] axis_sample_value();
        int mag;
        case ($urandom_range(0, 7))
            0, 1: mag = int'(DPAD_THRESH) + $urandom_range(0, 2) - 1;
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return 16'h8001;
                    default: return 16'h0000;
                endcase
            end
            3: mag = db_now + $urandom_range(0, 2) - 1;
            default: return 16'($urandom);
        endcase
        return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
    endfunction

    // Mostly well-formed events; a slice of raw bytes keeps every bit moving.
    function automatic t_in_word random_word();
        t_in_word    w;
        int          pick;
        logic        init_flag;
        w.axis_select = 3'($urandom_range(0, 7));
        w.event_type  = 8'($urandom);
        w.event_number = 8'($urandom);
        w.event_value = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 15)      w.action = ACT_FRAME;
        else if (pick < 80) w.action = ACT_EVENT;
        else if (pick < 95) w.action = ACT_QUERY;
        else                w.action = ACT_SPARE;
        init_flag = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            w.event_type = {init_flag, EV_BUTTON};
            if ($urandom_range(0, 99) < 85) w.event_number = 8'($urandom_range(0, 15));
            w.event_value = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 65535));
        end else if (pick < 90) begin
            w.event_type = {init_flag, EV_AXIS};
            pick = $urandom_range(0, 99);
            if (pick < 40)
                w.event_number = $urandom_range(0, 1) ? {5'd0, AXIS_DPAD_X}
                                                      : {5'd0, AXIS_DPAD_Y};
            else if (pick < 85)
                w.event_number = 8'($urandom_range(0, 7));
            w.event_value = axis_sample_value();
        end
        return w;
    endfunction

    // Holds the word until the block takes it; optional idle cycles first.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    // Stop sending and wait for every predicted report to come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen.
    // The bus then idles so back-to-back writes start on a fresh edge.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == DB_ADDR) begin
            db_now = int'(data[15:0]);
            db_writes++;
        end
        @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_word(random_word());
    endtask

    // Corner walk, deadband at its reset value of 800.
    task automatic run_directed();
        // nothing touched yet: all zero
        send_word(make_word(ACT_QUERY, 8'd0, 8'd0, 16'd0, AXIS_LEFT_X));
        // lowest and highest button, second one with init flag and a negative level
        send_word(make_word(ACT_EVENT, {1'b0, EV_BUTTON}, 8'd0, 16'd1, AXIS_LEFT_Y));
        send_word(make_word(ACT_EVENT, {1'b1, EV_BUTTON}, 8'd15, 16'h8000, AXIS_LEFT_X));
        send_word(make_word(ACT_FRAME, 8'hff, 8'hff, 16'hffff, 3'd2));
        // release after a frame start shows up in the released mask
        send_word(make_word(ACT_EVENT, {1'b0, EV_BUTTON}, 8'd0, 16'd0, 3'd3));
        // button numbers past the top change nothing
        send_word(make_word(ACT_EVENT, {1'b0, EV_BUTTON}, 8'd16, 16'd1, 3'd4));
        send_word(make_word(ACT_EVENT, {1'b1, EV_BUTTON}, 8'd255, 16'h7fff, 3'd5));
        // raw axis rails
        send_word(make_word(ACT_EVENT, {1'b0, EV_AXIS}, 8'd0, 16'h8000, AXIS_LEFT_X));
        send_word(make_word(ACT_EVENT, {1'b1, EV_AXIS}, 8'd1, 16'h7fff, AXIS_LEFT_Y));
        // deadband edges on a plain axis
        send_word(make_word(ACT_EVENT, {1'b0, EV_AXIS}, 8'd2, 16'(799), 3'd2));
        send_word(make_word(ACT_EVENT, {1'b0, EV_AXIS}, 8'd2, 16'(800), 3'd2));
        send_word(make_word(ACT_EVENT, {1'b0, EV_AXIS}, 8'd2, 16'(-800), 3'd2));
        send_word(make_word(ACT_EVENT, {1'b0, EV_AXIS}, 8'd2, 16'(-799), 3'd2));
        // dpad x: threshold itself is not enough, one past sets right, then left
        send_word(make_word(ACT_EVENT, {1'b0, EV_AXIS}, {5'd0, AXIS_DPAD_X}, 16'(10000),
                            AXIS_DPAD_X));
        send_word(make_word(ACT_EVENT, {1'b0, EV_AXIS}, {5'd0, AXIS_DPAD_X}, 16'(10001),
                            AXIS_LEFT_X));
        send_word(make_word(ACT_EVENT, {1'b1, EV_AXIS}, {5'd0, AXIS_DPAD_X}, 16'(-10001),
                            AXIS_DPAD_X));
        // dpad y: up, then down
        send_word(make_word(ACT_EVENT, {1'b0, EV_AXIS}, {5'd0, AXIS_DPAD_Y}, 16'(-10001),
                            AXIS_LEFT_Y));
        send_word(make_word(ACT_FRAME, 8'd0, 8'd0, 16'd0, AXIS_DPAD_Y));
        send_word(make_word(ACT_EVENT, {1'b0, EV_AXIS}, {5'd0, AXIS_DPAD_Y}, 16'(20000),
                            AXIS_DPAD_Y));
        // axis number past the table: no sample stored
        send_word(make_word(ACT_EVENT, {1'b0, EV_AXIS}, 8'd200, 16'h1234, 3'd7));
        // other types, with and without init flag, change nothing
        send_word(make_word(ACT_EVENT, 8'd0, 8'd3, 16'h4321, 3'd3));
        send_word(make_word(ACT_EVENT, 8'h83, 8'd3, 16'h4321, 3'd3));
        send_word(make_word(ACT_EVENT, 8'hff, 8'd6, 16'h7fff, AXIS_DPAD_X));
        // unused action code and back to center
        send_word(make_word(ACT_SPARE, {1'b0, EV_AXIS}, 8'd6, 16'h7fff, AXIS_LEFT_X));
        send_word(make_word(ACT_EVENT, {1'b0, EV_AXIS}, {5'd0, AXIS_DPAD_Y}, 16'(-10000),
                            AXIS_LEFT_Y));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain();

        // free running: both deadband extremes
        idle_pct = 0;  stall_pct = 0;
        apb_write(DB_ADDR, 32'd0);
        run_random(HALF_RUN);
        drain();
        apb_write(DB_ADDR, 32'd32768);
        run_random(HALF_RUN);
        drain();

        // slow sender
        idle_pct = 79; stall_pct = 0;
        apb_write(DB_ADDR, 32'($urandom_range(0, 32768)));
        run_random(HALF_RUN);
        drain();
        apb_write(DB_ADDR, 32'd1);
        run_random(HALF_RUN);
        drain();

        // slow sink; junk in the upper data bits and a write to the hole
        idle_pct = 0;  stall_pct = 79;
        apb_write(DB_ADDR, {16'ha5a5, 16'd1200});
        apb_write(SPARE_ADDR, $urandom);
        run_random(HALF_RUN);
        drain();
        apb_write(DB_ADDR, 32'($urandom_range(0, 32768)));
        run_random(HALF_RUN);
        drain();

        // both slow, ending back at the reset value
        idle_pct = 35; stall_pct = 35;
        apb_write(DB_ADDR, 32'd32768);
        run_random(HALF_RUN);
        drain();
        apb_write(DB_ADDR, 32'(DEADBAND_RESET));
        run_random(HALF_RUN);
        drain();

        repeat (4) @(posedge i_clk);
        $display("sent %0d words, %0d reports compared, %0d deadband writes",
                 words_sent, reports, db_writes);
        $display("pacing: free, slow sender, slow sink, both slow");
        if (errors == 0)
            $display("tb_gamepad_event_state_tracker: done, clean");
        else
            $display("tb_gamepad_event_state_tracker: done, errors");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #3_200_000;
        $display("tb_gamepad_event_state_tracker: done, errors");
        $finish;
    end

endmodule

[gamepad_event_state_tracker.f]
sv/gest_pkg.sv
sv/gest_cfg.sv
sv/gest_core.sv
sv/gest_result.sv
sv/gamepad_event_state_tracker.sv
dv/gest_state_checker.sv
dv/tb_gamepad_event_state_tracker.sv
